[rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg: shared constants and types for the triangle face normal unit
// Fixed-point formats, normalization target and the control sideband.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int OUT_W            = 16;

	// magnitudes are normalized so the largest one has its top bit here
	localparam int NORM_POS = 29;
	localparam int MAG_W    = NORM_POS + 1;

	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} side_t;

endpackage

[rtl/tfn_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// tfn_sqrt_pipe: pipelined integer square root
// One result bit per stage; returns the floor root and the remainder.
// ----------------------------------------------------------------------------
module tfn_sqrt_pipe #(
	parameter int SW     = 62,
	parameter int RTW    = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [SW-1:0]     in_s,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [RTW-1:0]    out_root,
	output logic [SW-1:0]     out_rem,
	output logic [SIDE_W-1:0] out_side
);

	logic [SW-1:0]     rem_s  [0:RTW];
	logic [SW-1:0]     root_s [0:RTW];
	logic [SIDE_W-1:0] side_s [0:RTW];
	logic              vld_s  [0:RTW];

	assign rem_s[0]  = in_s;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < RTW; k++) begin : g_step
		localparam logic [SW-1:0] BIT = SW'(1) << (2 * (RTW - 1 - k));
		logic [SW-1:0] trial;
		logic [SW-1:0] rem_nx;
		logic [SW-1:0] root_nx;

		always_comb begin
			trial = root_s[k] + BIT;
			if (rem_s[k] >= trial) begin
				rem_nx  = rem_s[k] - trial;
				root_nx = (root_s[k] >> 1) + BIT;
			end else begin
				rem_nx  = rem_s[k];
				root_nx = root_s[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_nx;
				root_s[k+1] <= root_nx;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[RTW];
	assign out_root = root_s[RTW][RTW-1:0];
	assign out_rem  = rem_s[RTW];
	assign out_side = side_s[RTW];

endmodule

[rtl/tfn_div_pipe.sv]
// ----------------------------------------------------------------------------
// tfn_div_pipe: three-lane pipelined restoring divider
// Shared divisor, one quotient bit per stage in each lane.
// ----------------------------------------------------------------------------
module tfn_div_pipe #(
	parameter int NW     = 45,
	parameter int RW     = 32,
	parameter int QB     = 16,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [2:0][NW-1:0]  in_num,
	input  logic [RW-1:0]       in_den,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_vld,
	output logic [2:0][QB-1:0]  out_quo,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int DW = RW + QB;

	logic [2:0][DW-1:0] rem_s  [0:QB];
	logic [2:0][QB-1:0] quo_s  [0:QB];
	logic [RW-1:0]      den_s  [0:QB];
	logic [SIDE_W-1:0]  side_s [0:QB];
	logic               vld_s  [0:QB];

	for (genvar l = 0; l < 3; l++) begin : g_in
		assign rem_s[0][l] = DW'(in_num[l]);
		assign quo_s[0][l] = '0;
	end
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int J = QB - 1 - k;
		logic [DW-1:0]      dsh;
		logic [2:0][DW-1:0] rem_nx;
		logic [2:0][QB-1:0] quo_nx;

		always_comb begin
			dsh = DW'(den_s[k]) << J;
			for (int l = 0; l < 3; l++) begin
				if (rem_s[k][l] >= dsh) begin
					rem_nx[l] = rem_s[k][l] - dsh;
					quo_nx[l] = quo_s[k][l] | (QB'(1) << J);
				end else begin
					rem_nx[l] = rem_s[k][l];
					quo_nx[l] = quo_s[k][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_nx;
				quo_s[k+1]  <= quo_nx;
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[QB];
	assign out_quo  = quo_s[QB];
	assign out_side = side_s[QB];

endmodule

[rtl/triangle_face_normal_unit.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal_unit: unit face normal of one triangle
// Negated cross product of (v1-v2, v3-v2), scaled to unit length, Q2.14.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one triangle (nine Q8.8
//   coordinates) per transfer. Output channel out_valid/out_ready carries
//   normal_x/y/z in signed Q2.14 plus the degenerate flag.
//   Throughput: one triangle per cycle while out_ready does not hold back a
//   pending result. The pipe has eight setup stages (edges, products,
//   cross, magnitude, leading one, normalize, squares, sum), one stage per
//   root bit in the square root pipe, a rounding stage, one stage per
//   quotient bit in the divider, and the output register.
//   The whole pipe advances together; when the receiver holds out_ready
//   low with a result pending, every stage holds and in_ready drops, so
//   nothing is lost or repeated. While the output register is empty the
//   pipe advances whatever out_ready is.
//   Reset clears all valid bits; no other state is kept.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit #(
	parameter int COORD_BITS       = tfn_pkg::COORD_BITS,
	parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] v1_x,
	input  logic signed [COORD_BITS-1:0] v1_y,
	input  logic signed [COORD_BITS-1:0] v1_z,
	input  logic signed [COORD_BITS-1:0] v2_x,
	input  logic signed [COORD_BITS-1:0] v2_y,
	input  logic signed [COORD_BITS-1:0] v2_z,
	input  logic signed [COORD_BITS-1:0] v3_x,
	input  logic signed [COORD_BITS-1:0] v3_y,
	input  logic signed [COORD_BITS-1:0] v3_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [tfn_pkg::OUT_W-1:0] normal_x,
	output logic signed [tfn_pkg::OUT_W-1:0] normal_y,
	output logic signed [tfn_pkg::OUT_W-1:0] normal_z,
	output logic                         degenerate
);

	localparam int EW    = COORD_BITS + 1;
	localparam int PW    = 2 * EW;
	localparam int XW    = PW + 1;
	localparam int MW    = PW;
	localparam int PSW   = $clog2(MW);
	localparam int NP    = tfn_pkg::NORM_POS;
	localparam int MAGW  = tfn_pkg::MAG_W;
	localparam int SQW   = 2 * MAGW;
	localparam int SUMW  = SQW + 2;
	localparam int RTW   = MAGW + 1;
	localparam int RW    = RTW + 1;
	localparam int F     = NORMAL_FRAC_BITS;
	localparam int QB    = F + 2;
	localparam int NW    = MAGW + F + 1;
	localparam int OW    = tfn_pkg::OUT_W;
	localparam int TW    = (QB + 1 > OW) ? QB + 1 : OW;
	localparam int CTLW  = $bits(tfn_pkg::side_t);
	localparam int SQSW  = 3 * MAGW + CTLW;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: edge vectors
	logic                        vld_s1;
	logic signed [2:0][EW-1:0]   a_s1, b_s1;

	// ---------------- stage 2: six partial products
	logic                        vld_s2;
	logic signed [5:0][PW-1:0]   p_s2;

	// ---------------- stage 3: cross components
	logic                        vld_s3;
	logic signed [2:0][XW-1:0]   c_s3;

	// ---------------- stage 4: magnitudes and signs
	logic                        vld_s4;
	logic [2:0][MW-1:0]          mag_s4;
	tfn_pkg::side_t              ctl_s4;

	// ---------------- stage 5: leading one position
	logic                        vld_s5;
	logic [2:0][MW-1:0]          mag_s5;
	logic [PSW-1:0]              pos_s5;
	tfn_pkg::side_t              ctl_s5;

	// ---------------- stage 6..8: normalize, square, sum
	logic                        vld_s6, vld_s7, vld_s8;
	logic [2:0][MAGW-1:0]        m_s6, m_s7, m_s8;
	logic [2:0][SQW-1:0]         sq_s7;
	logic [SUMW-1:0]             sum_s8;
	tfn_pkg::side_t              ctl_s6, ctl_s7, ctl_s8;

	// ---------------- rounding stage
	logic                        vld_s9;
	logic [2:0][NW-1:0]          num_s9;
	logic [RW-1:0]               r_s9;
	tfn_pkg::side_t              ctl_s9;

	// ---------------- output stage
	logic signed [OW-1:0]        nx_q, ny_q, nz_q;
	logic                        degen_q, vld_q;

	// comb helpers
	logic [2:0][MW-1:0]          mag_c;
	logic [2:0]                  neg_c;
	logic [MW-1:0]               or_c;
	logic [PSW-1:0]              pos_c;
	logic [2:0][MAGW-1:0]        m_c;
	logic [RTW-1:0]              root_w;
	logic [SUMW-1:0]             rem_w;
	logic [SQSW-1:0]             sq_side_w;
	logic                        sq_vld_w;
	logic [2:0][MAGW-1:0]        m_w;
	tfn_pkg::side_t              ctl_w;
	logic [RW-1:0]               r_c;
	logic [2:0][QB-1:0]          quo_w;
	logic                        dv_vld_w;
	tfn_pkg::side_t              dv_ctl_w;
	logic [2:0][OW-1:0]          nout_c;

	// valid chain of the setup, rounding and output stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= sq_vld_w;
			vld_q  <= dv_vld_w;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = c_s3[i][XW-1];
			mag_c[i] = neg_c[i] ? MW'(-c_s3[i]) : MW'(c_s3[i]);
		end
	end

	always_comb begin
		or_c  = mag_s4[0] | mag_s4[1] | mag_s4[2];
		pos_c = '0;
		for (int i = 0; i < MW; i++) begin
			if (or_c[i]) begin
				pos_c = PSW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_c[i] = MAGW'(((MW + NP)'(mag_s5[i]) << NP) >> pos_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= $signed({v1_x[COORD_BITS-1], v1_x}) - $signed({v2_x[COORD_BITS-1], v2_x});
			a_s1[1] <= $signed({v1_y[COORD_BITS-1], v1_y}) - $signed({v2_y[COORD_BITS-1], v2_y});
			a_s1[2] <= $signed({v1_z[COORD_BITS-1], v1_z}) - $signed({v2_z[COORD_BITS-1], v2_z});
			b_s1[0] <= $signed({v3_x[COORD_BITS-1], v3_x}) - $signed({v2_x[COORD_BITS-1], v2_x});
			b_s1[1] <= $signed({v3_y[COORD_BITS-1], v3_y}) - $signed({v2_y[COORD_BITS-1], v2_y});
			b_s1[2] <= $signed({v3_z[COORD_BITS-1], v3_z}) - $signed({v2_z[COORD_BITS-1], v2_z});

			p_s2[0] <= $signed(a_s1[2]) * $signed(b_s1[1]);
			p_s2[1] <= $signed(a_s1[1]) * $signed(b_s1[2]);
			p_s2[2] <= $signed(a_s1[0]) * $signed(b_s1[2]);
			p_s2[3] <= $signed(a_s1[2]) * $signed(b_s1[0]);
			p_s2[4] <= $signed(a_s1[1]) * $signed(b_s1[0]);
			p_s2[5] <= $signed(a_s1[0]) * $signed(b_s1[1]);

			c_s3[0] <= $signed({p_s2[0][PW-1], p_s2[0]}) - $signed({p_s2[1][PW-1], p_s2[1]});
			c_s3[1] <= $signed({p_s2[2][PW-1], p_s2[2]}) - $signed({p_s2[3][PW-1], p_s2[3]});
			c_s3[2] <= $signed({p_s2[4][PW-1], p_s2[4]}) - $signed({p_s2[5][PW-1], p_s2[5]});

			mag_s4       <= mag_c;
			ctl_s4.neg   <= neg_c;
			ctl_s4.degen <= (c_s3[0] == '0) && (c_s3[1] == '0) && (c_s3[2] == '0);

			mag_s5 <= mag_s4;
			pos_s5 <= pos_c;
			ctl_s5 <= ctl_s4;

			m_s6   <= m_c;
			ctl_s6 <= ctl_s5;

			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= SQW'(m_s6[i]) * SQW'(m_s6[i]);
			end
			m_s7   <= m_s6;
			ctl_s7 <= ctl_s6;

			sum_s8 <= SUMW'(sq_s7[0]) + SUMW'(sq_s7[1]) + SUMW'(sq_s7[2]);
			m_s8   <= m_s7;
			ctl_s8 <= ctl_s7;
		end
	end

	tfn_sqrt_pipe #(
		.SW     (SUMW),
		.RTW    (RTW),
		.SIDE_W (SQSW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s8),
		.in_s     (sum_s8),
		.in_side  ({m_s8, ctl_s8}),
		.out_vld  (sq_vld_w),
		.out_root (root_w),
		.out_rem  (rem_w),
		.out_side (sq_side_w)
	);

	assign m_w   = sq_side_w[SQSW-1:CTLW];
	assign ctl_w = sq_side_w[CTLW-1:0];

	// round to nearest: bump when the remainder exceeds the floor root
	assign r_c = RW'(root_w) + RW'(rem_w > SUMW'(root_w));

	always_ff @(posedge clk) begin
		if (en) begin
			r_s9   <= r_c;
			ctl_s9 <= ctl_w;
			for (int i = 0; i < 3; i++) begin
				num_s9[i] <= (NW'(m_w[i]) << F) + NW'(r_c >> 1);
			end
		end
	end

	tfn_div_pipe #(
		.NW     (NW),
		.RW     (RW),
		.QB     (QB),
		.SIDE_W (CTLW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s9),
		.in_num   (num_s9),
		.in_den   (r_s9),
		.in_side  (ctl_s9),
		.out_vld  (dv_vld_w),
		.out_quo  (quo_w),
		.out_side (dv_ctl_w)
	);

	always_comb begin
		logic [TW-1:0] t;
		for (int i = 0; i < 3; i++) begin
			t = TW'(quo_w[i]);
			if (t > (TW'(1) << F)) begin
				t = TW'(1) << F;
			end
			if (dv_ctl_w.neg[i]) begin
				t = -t;
			end
			nout_c[i] = dv_ctl_w.degen ? '0 : t[OW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q    <= nout_c[0];
			ny_q    <= nout_c[1];
			nz_q    <= nout_c[2];
			degen_q <= dv_ctl_w.degen;
		end
	end

	assign out_valid  = vld_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;
	assign degenerate = degen_q;

endmodule

[rtl/tfn_checker.sv]
// ----------------------------------------------------------------------------
// tfn_checker: port-level checks for the triangle face normal unit
// Bound to the top level; watches the handshakes and the degenerate flag against the normal.
// ----------------------------------------------------------------------------
module tfn_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [tfn_pkg::OUT_W-1:0] normal_x,
	input logic signed [tfn_pkg::OUT_W-1:0] normal_y,
	input logic signed [tfn_pkg::OUT_W-1:0] normal_z,
	input logic                             degenerate
);

	localparam logic [tfn_pkg::OUT_W-1:0] ZERO = '0;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(normal_x) &&
		$stable(normal_y) && $stable(normal_z) && $stable(degenerate))
		else $error("stalled result changed");

	// a degenerate triangle reports a zero normal
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |->
		normal_x == ZERO && normal_y == ZERO && normal_z == ZERO)
		else $error("degenerate result with nonzero normal");

	// a good normal is never all zero: the largest component is at least about 1/sqrt(3)
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |->
		normal_x != ZERO || normal_y != ZERO || normal_z != ZERO)
		else $error("zero normal without degenerate flag");

	// the input side is only held off by a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);
